[hw/rtl/table_linear_interpolator_macros.svh]
// Assertion helpers; clock and reset are the standard port names.
`ifndef TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
`define TLI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TLI_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define TLI_ASSERT(lbl, prop, msg)
`define TLI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hw/rtl/tli_pkg.sv]
package tli_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = 8;
   localparam int DATA_W      = 32;
   localparam int COUNT_W     = 9;

   localparam logic [1:0] CSR_POINT_COUNT  = 2'd0;
   localparam logic [1:0] CSR_ORIGIN       = 2'd1;
   localparam logic [1:0] CSR_INVERSE_STEP = 2'd2;

   localparam logic [COUNT_W-1:0] POINT_COUNT_RESET  = 9'd2;
   localparam logic [DATA_W-1:0]  ORIGIN_RESET       = 32'd0;
   localparam logic [DATA_W-1:0]  INVERSE_STEP_RESET = 32'd65536;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

endpackage

[hw/rtl/table_linear_interpolator.sv]
// Equally spaced lookup table with linear interpolation. A write word stores one signed
// 32-bit entry; a query word maps its Q16.16 sample through (sample - origin) * inverse_step
// onto the table and returns the lerp of the two neighboring entries, truncated toward zero,
// clamped to the first entry below the span and the last entry in use at or past its end.
// One word is accepted every cycle while req_stall is low, writes and queries alike; a query
// result passes through the input capture register, six datapath stages (subtract, two
// multiplies, the table memory read, a subtract, a multiply) and the output register. The
// table is a 256 x 32 memory with one write and two reads per cycle. A one-word skid buffer
// behind the output register absorbs a stall; req_stall rises only once that buffer is full.
// Entries read before they are written return undefined data. Write the CSRs only while idle.
`include "table_linear_interpolator_macros.svh"

module table_linear_interpolator
   import tli_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_type,
   input  logic [ADDR_W-1:0]          req_entry_index,
   input  logic signed [DATA_W-1:0]   req_entry_value,
   input  logic signed [DATA_W-1:0]   req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [DATA_W-1:0]   rsp_interpolated,
   input  logic                       csr_wr_en,
   input  logic [1:0]                 csr_index,
   input  logic [DATA_W-1:0]          csr_data
);

   logic [COUNT_W-1:0] point_count_ff;
   logic [DATA_W-1:0]  origin_ff;
   logic [DATA_W-1:0]  inverse_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff  <= POINT_COUNT_RESET;
         origin_ff       <= ORIGIN_RESET;
         inverse_step_ff <= INVERSE_STEP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_POINT_COUNT:  point_count_ff  <= csr_data[COUNT_W-1:0];
            CSR_ORIGIN:       origin_ff       <= csr_data;
            CSR_INVERSE_STEP: inverse_step_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic adv;
   logic skid_full_ff;

   assign adv       = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // stage 1: capture
   logic               s1_vld_ff;
   req_kind_type       s1_kind_ff;
   logic [ADDR_W-1:0]  s1_idx_ff;
   logic [DATA_W-1:0]  s1_value_ff;
   logic [DATA_W-1:0]  s1_sample_ff;

   // stage 2: offset from origin
   logic [DATA_W:0]    s2_d_in;
   logic               s2_low_in;
   logic               s2_vld_ff;
   req_kind_type       s2_kind_ff;
   logic [ADDR_W-1:0]  s2_idx_ff;
   logic [DATA_W-1:0]  s2_value_ff;
   logic [DATA_W-1:0]  s2_dmag_ff;
   logic               s2_low_ff;

   assign s2_d_in   = {s1_sample_ff[DATA_W-1], s1_sample_ff} - {origin_ff[DATA_W-1], origin_ff};
   assign s2_low_in = s2_d_in[DATA_W] || (s2_d_in == '0) || (inverse_step_ff == '0);

   // stage 3: normalized position
   logic [2*DATA_W-1:0] s3_t_in;
   logic                s3_vld_ff;
   req_kind_type        s3_kind_ff;
   logic [ADDR_W-1:0]   s3_idx_ff;
   logic [DATA_W-1:0]   s3_value_ff;
   logic [2*DATA_W-1:0] s3_t_ff;
   logic                s3_low_ff;

   assign s3_t_in = (2*DATA_W)'(s2_dmag_ff) * (2*DATA_W)'(inverse_step_ff);

   // stage 4: table address and weight
   logic [ADDR_W-1:0]        nm1;
   logic [DATA_W+ADDR_W-1:0] s4_p_in;
   logic                     s4_high_in;
   logic [ADDR_W-1:0]        s4_addr_in;
   logic [ADDR_W-1:0]        s4_addr_b_in;
   logic [DATA_W-1:0]        s4_w_in;
   logic                     s4_vld_ff;
   req_kind_type             s4_kind_ff;
   logic [ADDR_W-1:0]        s4_addr_a_ff;
   logic [ADDR_W-1:0]        s4_addr_b_ff;
   logic [DATA_W-1:0]        s4_w_ff;
   logic [DATA_W-1:0]        s4_value_ff;

   always_comb begin
      if (point_count_ff < COUNT_W'(2)) begin
         nm1 = ADDR_W'(1);
      end else if (point_count_ff > COUNT_W'(TABLE_DEPTH)) begin
         nm1 = ADDR_W'(TABLE_DEPTH - 1);
      end else begin
         nm1 = ADDR_W'(point_count_ff - COUNT_W'(1));
      end
   end

   assign s4_p_in    = (DATA_W+ADDR_W)'(s3_t_ff[DATA_W-1:0]) * (DATA_W+ADDR_W)'(nm1);
   assign s4_high_in = |s3_t_ff[2*DATA_W-1:DATA_W];

   // clamp or write: read the same entry on both ports
   always_comb begin
      if (s3_kind_ff == REQ_WRITE) begin
         s4_addr_in   = s3_idx_ff;
         s4_addr_b_in = s3_idx_ff;
         s4_w_in      = '0;
      end else if (s3_low_ff) begin
         s4_addr_in   = '0;
         s4_addr_b_in = '0;
         s4_w_in      = '0;
      end else if (s4_high_in) begin
         s4_addr_in   = nm1;
         s4_addr_b_in = nm1;
         s4_w_in      = '0;
      end else begin
         s4_addr_in   = s4_p_in[DATA_W+ADDR_W-1:DATA_W];
         s4_addr_b_in = s4_p_in[DATA_W+ADDR_W-1:DATA_W] + ADDR_W'(1);
         s4_w_in      = s4_p_in[DATA_W-1:0];
      end
   end

   // stage 5: table memory
   logic [DATA_W-1:0] point_table [TABLE_DEPTH];
   logic              s5_vld_ff;
   logic [DATA_W-1:0] s5_lo_ff;
   logic [DATA_W-1:0] s5_hi_ff;
   logic [DATA_W-1:0] s5_w_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (s4_vld_ff && (s4_kind_ff == REQ_WRITE)) begin
            point_table[s4_addr_a_ff] <= s4_value_ff;
         end
         s5_lo_ff <= point_table[s4_addr_a_ff];
         s5_hi_ff <= point_table[s4_addr_b_ff];
      end
   end

   // stage 6: neighbor difference
   logic [DATA_W:0]   s6_delta_in;
   logic [DATA_W:0]   s6_negd_in;
   logic              s6_vld_ff;
   logic [DATA_W-1:0] s6_lo_ff;
   logic              s6_neg_ff;
   logic [DATA_W-1:0] s6_mag_ff;
   logic [DATA_W-1:0] s6_w_ff;

   assign s6_delta_in = {s5_hi_ff[DATA_W-1], s5_hi_ff} - {s5_lo_ff[DATA_W-1], s5_lo_ff};
   assign s6_negd_in  = (DATA_W+1)'(0) - s6_delta_in;

   // stage 7: weighted difference
   logic [2*DATA_W-1:0] s7_m_in;
   logic                s7_vld_ff;
   logic [DATA_W-1:0]   s7_lo_ff;
   logic                s7_neg_ff;
   logic [2*DATA_W-1:0] s7_m_ff;

   assign s7_m_in = (2*DATA_W)'(s6_w_ff) * (2*DATA_W)'(s6_mag_ff);

   // final sum, truncated toward zero
   logic [DATA_W-1:0] fin_q;
   logic              fin_r;
   logic [DATA_W+1:0] fin_lo;
   logic [DATA_W+1:0] fin_base;
   logic [DATA_W+1:0] fin_val;
   logic [DATA_W-1:0] result_in;

   assign fin_q  = s7_m_ff[2*DATA_W-1:DATA_W];
   assign fin_r  = |s7_m_ff[DATA_W-1:0];
   assign fin_lo = {{2{s7_lo_ff[DATA_W-1]}}, s7_lo_ff};

   always_comb begin
      if (s7_neg_ff) begin
         fin_base = fin_lo - {2'b00, fin_q} - (DATA_W+2)'(fin_r);
      end else begin
         fin_base = fin_lo + {2'b00, fin_q};
      end
      if (fin_base[DATA_W+1] && fin_r) begin
         fin_val = fin_base + (DATA_W+2)'(1);
      end else begin
         fin_val = fin_base;
      end
   end

   assign result_in = fin_val[DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff && (s4_kind_ff == REQ_QUERY);
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_kind_ff   <= req_kind_type'(req_type);
         s1_idx_ff    <= req_entry_index;
         s1_value_ff  <= req_entry_value;
         s1_sample_ff <= req_sample;

         s2_kind_ff   <= s1_kind_ff;
         s2_idx_ff    <= s1_idx_ff;
         s2_value_ff  <= s1_value_ff;
         s2_dmag_ff   <= s2_d_in[DATA_W-1:0];
         s2_low_ff    <= s2_low_in;

         s3_kind_ff   <= s2_kind_ff;
         s3_idx_ff    <= s2_idx_ff;
         s3_value_ff  <= s2_value_ff;
         s3_t_ff      <= s3_t_in;
         s3_low_ff    <= s2_low_ff;

         s4_kind_ff   <= s3_kind_ff;
         s4_addr_a_ff <= s4_addr_in;
         s4_addr_b_ff <= s4_addr_b_in;
         s4_w_ff      <= s4_w_in;
         s4_value_ff  <= s3_value_ff;

         s5_w_ff      <= s4_w_ff;

         s6_lo_ff     <= s5_lo_ff;
         s6_neg_ff    <= s6_delta_in[DATA_W];
         s6_mag_ff    <= s6_delta_in[DATA_W] ? s6_negd_in[DATA_W-1:0]
                                             : s6_delta_in[DATA_W-1:0];
         s6_w_ff      <= s5_w_ff;

         s7_lo_ff     <= s6_lo_ff;
         s7_neg_ff    <= s6_neg_ff;
         s7_m_ff      <= s7_m_in;
      end
   end

   // output register with one-word skid
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [DATA_W-1:0] skid_data_ff;
   logic              pop;

   assign pop = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (pop) begin
            skid_full_ff <= 1'b0;
         end
      end else if (rsp_valid_ff && !pop) begin
         if (s7_vld_ff) begin
            skid_full_ff <= 1'b1;
         end
      end else begin
         rsp_valid_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (pop) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (rsp_valid_ff && !pop) begin
         skid_data_ff <= result_in;
      end else begin
         rsp_data_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interpolated = rsp_data_ff;

   `TLI_ASSERT(a_skid_needs_output, skid_full_ff |-> rsp_valid_ff, "skid full without output word")
   `TLI_ASSERT(a_skid_on_stall, $rose(skid_full_ff) |-> $past(rsp_valid_ff && rsp_stall), "skid filled without a stall")
   `TLI_ASSERT(a_drain, (pop && !skid_full_ff && !s7_vld_ff) |=> !rsp_valid_ff, "output word repeated")

endmodule

[bench/tb_table_linear_interpolator.sv]
`timescale 1ns / 100ps

module tb_table_linear_interpolator;
   import tli_pkg::*;

   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 80;
   localparam int CYCLE_LIMIT  = 400000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_type = REQ_WRITE;
   logic [ADDR_W-1:0]         req_entry_index = '0;
   logic signed [DATA_W-1:0]  req_entry_value = '0;
   logic signed [DATA_W-1:0]  req_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]  rsp_interpolated;
   logic                      csr_wr_en = 1'b0;
   logic [1:0]                csr_index = CSR_POINT_COUNT;
   logic [DATA_W-1:0]         csr_data = '0;

   logic signed [DATA_W-1:0]  shadow_table [TABLE_DEPTH];
   logic [COUNT_W-1:0]        cur_point_count = POINT_COUNT_RESET;
   logic signed [DATA_W-1:0]  cur_origin = ORIGIN_RESET;
   logic [DATA_W-1:0]         cur_inv_step = INVERSE_STEP_RESET;
   logic signed [DATA_W-1:0]  pending_lerps [$];

   int  src_idle_pct = 16;
   int  snk_idle_pct = 16;
   logic hold_rsp = 1'b0;
   int  words_sent = 0;
   int  queries_sent = 0;
   int  results_checked = 0;
   int  mismatch_count = 0;
   int  settings_used = 0;
   int  cycle_count = 0;

   table_linear_interpolator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_interpolated (rsp_interpolated),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_table_linear_interpolator: FAIL");
      $finish;
   end

   function automatic logic signed [DATA_W-1:0] predict_lerp(logic signed [DATA_W-1:0] smp);
      longint      d, vlo, vhi, delta, val;
      logic [63:0] t, p, w, mag, m, q, r;
      int          n, lo;
      n = int'(cur_point_count);
      if (n < 2) n = 2;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      d = longint'(smp) - longint'(cur_origin);
      if (d <= 0 || cur_inv_step == '0) return shadow_table[0];
      t = 64'(d) * 64'(cur_inv_step);
      if (t[63:32] != '0) return shadow_table[n-1];
      p = t * 64'(n - 1);
      lo = int'(p[63:32]);
      w = {32'd0, p[31:0]};
      vlo = shadow_table[lo];
      vhi = shadow_table[lo+1];
      delta = vhi - vlo;
      mag = (delta < 0) ? -delta : delta;
      m = w * mag;
      q = {32'd0, m[63:32]};
      r = {32'd0, m[31:0]};
      if (delta >= 0) val = vlo + longint'(q);
      else val = vlo - longint'(q) - ((r != '0) ? 1 : 0);
      if (val < 0 && r != '0) val += 1;
      return val[DATA_W-1:0];
   endfunction

   // bias samples toward the table span and its two ends
   function automatic logic signed [DATA_W-1:0] pick_sample();
      longint      dend, d, s;
      logic [63:0] r;
      r = {$urandom, $urandom};
      if (cur_inv_step == '0) return $urandom;
      dend = longint'((64'h1_0000_0000 + 64'(cur_inv_step) - 1) / 64'(cur_inv_step));
      case ($urandom_range(7))
         0: return $urandom;
         1: d = longint'($urandom_range(4)) - 2;
         2: d = dend + longint'($urandom_range(4)) - 2;
         default: d = longint'(r % 64'(dend + dend / 4 + 1)) - dend / 8;
      endcase
      s = longint'(cur_origin) + d;
      return s[DATA_W-1:0];
   endfunction

   always @(posedge clock) begin : check_lerp
      logic signed [DATA_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lerps.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result: expected none, actual %0d",
                     $time, rsp_interpolated);
         end else begin
            want = pending_lerps.pop_front();
            results_checked++;
            if (rsp_interpolated !== want) begin
               mismatch_count++;
               $display("%0t: interpolated mismatch: expected %0d, actual %0d",
                        $time, want, rsp_interpolated);
            end
         end
      end
      rsp_stall <= hold_rsp || ($urandom_range(99) < snk_idle_pct);
   end

   task automatic send_word(input logic kind, input logic [ADDR_W-1:0] idx,
                            input logic signed [DATA_W-1:0] value,
                            input logic signed [DATA_W-1:0] smp);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_entry_index <= idx;
      req_entry_value <= value;
      req_sample      <= smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (kind == REQ_WRITE) begin
         shadow_table[idx] = value;
      end else begin
         queries_sent++;
         pending_lerps.push_back(predict_lerp(smp));
      end
   endtask

   task automatic send_write(input logic [ADDR_W-1:0] idx, input logic signed [DATA_W-1:0] value);
      send_word(REQ_WRITE, idx, value, $urandom);
   endtask

   task automatic send_query(input logic signed [DATA_W-1:0] smp);
      send_word(REQ_QUERY, ADDR_W'($urandom), $urandom, smp);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_lerps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      case (idx)
         CSR_POINT_COUNT:  cur_point_count = value[COUNT_W-1:0];
         CSR_ORIGIN:       cur_origin = value;
         CSR_INVERSE_STEP: cur_inv_step = value;
         default: ;
      endcase
   endtask

   task automatic program_setting(input logic [COUNT_W-1:0] count,
                                  input logic [DATA_W-1:0] org,
                                  input logic [DATA_W-1:0] inv);
      drain();
      write_csr(CSR_POINT_COUNT, DATA_W'(count));
      write_csr(CSR_ORIGIN, org);
      write_csr(CSR_INVERSE_STEP, inv);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic run_mix(input int words);
      repeat (words) begin
         if ($urandom_range(3) == 0) send_write(ADDR_W'($urandom_range(TABLE_DEPTH - 1)), $urandom);
         else send_query(pick_sample());
      end
   endtask

   task automatic load_table();
      for (int i = 0; i < TABLE_DEPTH; i++) send_write(ADDR_W'(i), $urandom);
   endtask

   // reset setting: two points, span of one unit from zero
   task automatic test_directed();
      send_write(0, 32'sh7fff_ffff);
      send_write(1, 32'sh8000_0000);
      send_query(32'sh8000_0000);
      send_query(-1);
      send_query(0);
      send_query(1);
      send_query(32'sh0000_8000);
      send_query(32'sh0000_ffff);
      send_query(32'sh0001_0000);
      send_query(32'sh7fff_ffff);
      send_write(0, 32'sh8000_0000);
      send_write(1, 32'sh7fff_ffff);
      send_query(1);
      send_query(32'sh0000_8000);
      send_query(32'sh0000_ffff);
      send_write(0, -5);
      send_write(1, 3);
      send_query(32'sh0000_4000);
      send_query(32'sh0000_c000);
      send_write(ADDR_W'(TABLE_DEPTH - 1), 32'sh7fff_ffff);
   endtask

   task automatic test_setting_sweep();
      program_setting(0, 0, 32'h0001_0000);
      run_mix(50);
      program_setting(1, 32'h8000_0000, 1);
      run_mix(50);
      program_setting(3, -32'sd327680, 32'h0000_4000);
      run_mix(50);
      program_setting(17, $urandom, $urandom >> 12);
      run_mix(50);
      program_setting(256, 32'h7fff_ffff, 32'hffff_ffff);
      run_mix(50);
      program_setting(257, 0, 32'h0000_0100);
      run_mix(50);
      program_setting(511, 32'h8000_0000, 0);
      run_mix(50);
      program_setting(255, 0, 32'h0001_0000);
      run_mix(50);
      program_setting(256, 32'hfff0_0000, 32'h0000_0001);
      run_mix(50);
      program_setting(64, $urandom, $urandom >> 8);
      run_mix(50);
   endtask

   task automatic test_backpressure();
      program_setting(256, 0, 32'h0000_0100);
      src_idle_pct = 0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      repeat (60) send_query(pick_sample());
      src_idle_pct = 16;
   endtask

   task automatic test_random_settings();
      logic [COUNT_W-1:0] count;
      for (int k = 0; k < 6; k++) begin
         count = ($urandom_range(9) == 0) ? COUNT_W'($urandom_range(511))
                                          : COUNT_W'($urandom_range(2, 256));
         program_setting(count, $urandom, $urandom >> $urandom_range(31));
         src_idle_pct = (k < 3) ? 16 : 0;
         snk_idle_pct = (k < 3) ? 16 : 0;
         run_mix(60);
      end
      src_idle_pct = 16;
      snk_idle_pct = 16;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      load_table();
      test_directed();
      test_setting_sweep();
      test_backpressure();
      test_random_settings();
      drain();
      $display("tb: %0d words sent, %0d queries, %0d results checked, %0d mismatches",
               words_sent, queries_sent, results_checked, mismatch_count);
      $display("tb: %0d register settings incl. out-of-range counts, zero and full-scale step",
               settings_used);
      if (mismatch_count == 0 && pending_lerps.size() == 0) begin
         $display("tb_table_linear_interpolator: PASS");
      end else begin
         $display("tb_table_linear_interpolator: FAIL");
      end
      $finish;
   end

endmodule

[table_linear_interpolator.f]
+incdir+hw/rtl
hw/rtl/tli_pkg.sv
hw/rtl/table_linear_interpolator.sv
bench/tb_table_linear_interpolator.sv
